// ----- rtl/wpm_pkg.sv -----
// ============================================================================
// wpm_pkg: shared types and constants for the peak magnitude tracker
// Register indexes, reset values, field widths and controller/datapath links.
// ============================================================================
package wpm_pkg;

    localparam int FIELD_W        = 16;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 8;
    localparam int CNT_W          = 8;
    localparam int DEF_AXIS_BITS  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SAMPLES = 8'd1;

    localparam logic [CFG_DATA_W-1:0] SAMPLE_PERIOD_RST  = 8'd10;
    localparam logic [CFG_DATA_W-1:0] WINDOW_SAMPLES_RST = 8'd200;

    typedef struct packed {
        logic accept;
        logic mul_en;
        logic cmp_en;
        logic sqrt_start;
        logic load_out;
    } wpm_cmd_t;

    typedef struct packed {
        logic active;
        logic report_due;
        logic sample_due;
        logic mul_last;
        logic sqrt_busy;
        logic out_free;
    } wpm_stat_t;

endpackage

// ----- rtl/wpm_ifs.sv -----
// ============================================================================
// wpm channel interfaces
// Tick input, report output and register write channels.
// ============================================================================
interface wpm_tick_if;
    import wpm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       system_on;
    logic signed [FIELD_W-1:0]  mag_x;
    logic signed [FIELD_W-1:0]  mag_y;
    logic signed [FIELD_W-1:0]  mag_z;

    modport source (output valid, system_on, mag_x, mag_y, mag_z, input ready);
    modport sink   (input valid, system_on, mag_x, mag_y, mag_z, output ready);
endinterface

interface wpm_report_if;
    import wpm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic        [FIELD_W-1:0]  peak_magnitude;
    logic signed [FIELD_W-1:0]  peak_x;
    logic signed [FIELD_W-1:0]  peak_y;
    logic signed [FIELD_W-1:0]  peak_z;

    modport source (output valid, peak_magnitude, peak_x, peak_y, peak_z, input ready);
    modport sink   (input valid, peak_magnitude, peak_x, peak_y, peak_z, output ready);
endinterface

interface wpm_cfg_if;
    import wpm_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/wpm_isqrt.sv -----
// ============================================================================
// wpm_isqrt: iterative floor square root
// Restoring digit-by-digit root, one result bit per cycle.
// ============================================================================
module wpm_isqrt
    import wpm_pkg::*;
#(
    parameter int W = 34
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [W-1:0]       operand,
    output logic               busy,
    output logic [W/2-1:0]     root
);

    logic [W-1:0] rem_reg,  rem_next;
    logic [W-1:0] root_reg, root_next;
    logic [W-1:0] bit_reg,  bit_next;
    logic [W-1:0] trial;

    assign trial = root_reg + bit_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            rem_next  = operand;
            root_next = '0;
            bit_next  = W'(1) << (W - 2);
        end
        else if (bit_reg != '0)
        begin
            if (rem_reg >= trial)
            begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= '0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = (bit_reg != '0);
    assign root = root_reg[W/2-1:0];

endmodule

// ----- rtl/wpm_ctrl.sv -----
// ============================================================================
// wpm_ctrl: tracker sequencer
// Runs sampling ticks through multiply and compare, report ticks through root.
// ============================================================================
module wpm_ctrl
    import wpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick_valid,
    output logic       tick_ready,
    input  wpm_stat_t  stat,
    output wpm_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_CMP  = 4'b0100,
        S_SQRT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        tick_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                tick_ready = 1'b1;
                if (tick_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.active && stat.report_due)
                    begin
                        cmd.sqrt_start = 1'b1;
                        state_next     = S_SQRT;
                    end
                    else if (stat.active && stat.sample_due)
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (stat.mul_last)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp_en = 1'b1;
                state_next = S_IDLE;
            end
            S_SQRT:
            begin
                // hold the root until the output register is free
                if (!stat.sqrt_busy && stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/wpm_datapath.sv -----
// ============================================================================
// wpm_datapath: tracker state, squared magnitude and report registers
// One shared multiplier over three axes, peak compare, root and output stage.
// ============================================================================
module wpm_datapath
    import wpm_pkg::*;
#(
    parameter int AXIS_BITS = DEF_AXIS_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  wpm_cmd_t                    cmd,
    output wpm_stat_t                   stat,
    input  logic                        system_on,
    input  logic signed [FIELD_W-1:0]   mag_x,
    input  logic signed [FIELD_W-1:0]   mag_y,
    input  logic signed [FIELD_W-1:0]   mag_z,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [FIELD_W-1:0]          out_mag,
    output logic signed [FIELD_W-1:0]   out_x,
    output logic signed [FIELD_W-1:0]   out_y,
    output logic signed [FIELD_W-1:0]   out_z
);

    localparam int N    = AXIS_BITS;
    localparam int SQ_W = 2 * N + 2;
    localparam int RT_W = SQ_W / 2;

    typedef logic signed [N-1:0] axis_t;

    logic [CFG_DATA_W-1:0] period_reg;
    logic [CFG_DATA_W-1:0] window_reg;

    logic              active_reg;
    logic [CNT_W-1:0]  ticks_reg;
    logic [CNT_W-1:0]  ticks_inc;
    logic [CNT_W-1:0]  count_reg;

    logic [SQ_W-1:0]   peak_sq_reg;
    axis_t             peak_x_reg, peak_y_reg, peak_z_reg;

    axis_t             smp_x_reg, smp_y_reg, smp_z_reg;
    logic [1:0]        mul_idx_reg;
    logic [2*N-1:0]    prod_reg;
    logic [SQ_W-1:0]   acc_reg;
    axis_t             mul_sel;
    logic [N-1:0]      mul_abs;

    axis_t             res_x_reg, res_y_reg, res_z_reg;
    logic              out_valid_reg;
    logic [FIELD_W-1:0] out_mag_reg;
    axis_t             out_x_reg, out_y_reg, out_z_reg;

    logic              sqrt_busy;
    logic [RT_W-1:0]   sqrt_root;

    assign ticks_inc = (ticks_reg == '1) ? ticks_reg : ticks_reg + CNT_W'(1);

    always_comb
    begin
        case (mul_idx_reg)
            2'd0:    mul_sel = smp_x_reg;
            2'd1:    mul_sel = smp_y_reg;
            default: mul_sel = smp_z_reg;
        endcase
    end

    assign mul_abs = mul_sel[N-1] ? N'(-mul_sel) : N'(mul_sel);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= SAMPLE_PERIOD_RST;
            window_reg <= WINDOW_SAMPLES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_PERIOD:  period_reg <= cfg_data;
                CFG_WINDOW_SAMPLES: window_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            ticks_reg     <= '0;
            count_reg     <= '0;
            peak_sq_reg   <= '0;
            peak_x_reg    <= '0;
            peak_y_reg    <= '0;
            peak_z_reg    <= '0;
            mul_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (!active_reg)
                begin
                    ticks_reg  <= ticks_inc;
                    active_reg <= system_on;
                end
                else if (stat.report_due)
                begin
                    // root runs on the old peak; clear the window now
                    ticks_reg   <= ticks_inc;
                    count_reg   <= '0;
                    peak_sq_reg <= '0;
                    peak_x_reg  <= '0;
                    peak_y_reg  <= '0;
                    peak_z_reg  <= '0;
                end
                else if (stat.sample_due)
                begin
                    ticks_reg   <= '0;
                    mul_idx_reg <= '0;
                end
                else
                begin
                    ticks_reg <= ticks_inc;
                    if (!system_on)
                    begin
                        active_reg <= 1'b0;
                    end
                end
            end

            if (cmd.mul_en)
            begin
                mul_idx_reg <= mul_idx_reg + 2'd1;
            end

            if (cmd.cmp_en)
            begin
                if (acc_reg > peak_sq_reg)
                begin
                    peak_sq_reg <= acc_reg;
                    peak_x_reg  <= smp_x_reg;
                    peak_y_reg  <= smp_y_reg;
                    peak_z_reg  <= smp_z_reg;
                end
                if (count_reg != '1)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            smp_x_reg <= mag_x[N-1:0];
            smp_y_reg <= mag_y[N-1:0];
            smp_z_reg <= mag_z[N-1:0];
            acc_reg   <= '0;
            res_x_reg <= peak_x_reg;
            res_y_reg <= peak_y_reg;
            res_z_reg <= peak_z_reg;
        end
        if (cmd.mul_en)
        begin
            if (mul_idx_reg != 2'd3)
            begin
                prod_reg <= mul_abs * mul_abs;
            end
            if (mul_idx_reg != 2'd0)
            begin
                acc_reg <= acc_reg + SQ_W'(prod_reg);
            end
        end
        if (cmd.load_out)
        begin
            out_mag_reg <= FIELD_W'(sqrt_root);
            out_x_reg   <= res_x_reg;
            out_y_reg   <= res_y_reg;
            out_z_reg   <= res_z_reg;
        end
    end

    wpm_isqrt #(
        .W (SQ_W)
    ) u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.sqrt_start),
        .operand (peak_sq_reg),
        .busy    (sqrt_busy),
        .root    (sqrt_root)
    );

    assign stat.active     = active_reg;
    assign stat.report_due = (count_reg >= window_reg);
    assign stat.sample_due = (ticks_inc >= period_reg);
    assign stat.mul_last   = (mul_idx_reg == 2'd3);
    assign stat.sqrt_busy  = sqrt_busy;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_mag   = out_mag_reg;
    assign out_x     = FIELD_W'(out_x_reg);
    assign out_y     = FIELD_W'(out_y_reg);
    assign out_z     = FIELD_W'(out_z_reg);

endmodule

// ----- rtl/windowed_peak_magnitude_tracker.sv -----
// ============================================================================
// windowed_peak_magnitude_tracker: peak squared magnitude over a sample window
// Samples 3-axis readings on a tick count and reports the root of the peak.
// ============================================================================
// A plain tick is taken in the idle state alone; a sampling tick passes accept,
//   the one shared multiplier for each axis in turn, then the peak compare.
// A report tick waits for the bit-serial square root and a free output register;
//   the result then sits in the output register while new ticks are taken.
// Reset clears all tracker state; sample_period resets to 10, window_samples to 200.
module windowed_peak_magnitude_tracker
    import wpm_pkg::*;
#(
    parameter int AXIS_BITS = DEF_AXIS_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    wpm_tick_if.sink      tick,
    wpm_report_if.source  report,
    wpm_cfg_if.sink       cfg
);

    wpm_cmd_t  cmd;
    wpm_stat_t stat;

    assign cfg.ready = 1'b1;

    wpm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick.valid),
        .tick_ready (tick.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    wpm_datapath #(
        .AXIS_BITS (AXIS_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .system_on (tick.system_on),
        .mag_x     (tick.mag_x),
        .mag_y     (tick.mag_y),
        .mag_z     (tick.mag_z),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_valid (report.valid),
        .out_ready (report.ready),
        .out_mag   (report.peak_magnitude),
        .out_x     (report.peak_x),
        .out_y     (report.peak_y),
        .out_z     (report.peak_z)
    );

    a_no_tick_during_root: assert property (@(posedge clk) disable iff (!rst_n)
        (tick.valid && tick.ready) |-> !stat.sqrt_busy)
        else $error("tick accepted while root unit busy");

    a_root_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_start |=> stat.sqrt_busy)
        else $error("root unit did not start");

    a_load_shows_report: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> report.valid)
        else $error("loaded report beat not presented");

endmodule
